// ===== src/tlvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared constants and types for the TLV record stream parser.
// ----------------------------------------------------------------------------
package tlvp_pkg;

   localparam int OFFSET_BITS     = 24;
   localparam int ERR_OFFSET_BITS = 24;
   localparam int LEN_BITS        = 16;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   localparam logic [7:0] TYPE_TEXT = 8'd1;
   localparam logic [7:0] TYPE_INT  = 8'd2;

   localparam logic [7:0] TEXT_LOW  = 8'd32;
   localparam logic [7:0] TEXT_HIGH = 8'd126;

   localparam logic [LEN_BITS-1:0] INT_LEN       = 16'd4;
   localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = 16'd32;

   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_INT     = 3'd1;
   localparam logic [2:0] KIND_EMPTY   = 3'd2;
   localparam logic [2:0] KIND_OK      = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   localparam logic ERR_TRUNCATED = 1'b0;
   localparam logic ERR_INVALID   = 1'b1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [2:0]                 kind;
      logic [7:0]                 record_type;
      logic [7:0]                 payload_byte;
      logic                       record_end;
      logic signed [31:0]         int_value;
      logic                       error_code;
      logic [ERR_OFFSET_BITS-1:0] error_offset;
      logic                       last;
   } result_type;

   // up to two results produced by one input transaction
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type res0;
      result_type res1;
   } result_pair_type;

endpackage

// ===== src/tlvp_core.sv =====
// ----------------------------------------------------------------------------
// tlvp_core
// Parser state and per-byte decode; yields up to two results per byte.
// ----------------------------------------------------------------------------
module tlvp_core
   import tlvp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                buffer_end,
   input  logic [LEN_BITS-1:0] max_len,
   output result_pair_type     results
);

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_VALUE,
      PH_ERROR
   } phase_type;

   phase_type            phase_ff,  phase_in;
   logic [7:0]           type_ff,   type_in;
   logic [LEN_BITS-1:0]  len_ff,    len_in;
   logic [LEN_BITS-1:0]  rem_ff,    rem_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] pos_ff,   pos_in;
   logic                 inv_ff,    inv_in;
   logic [31:0]          acc_ff,    acc_in;

   logic [LEN_BITS-1:0]  len_full;
   logic [LEN_BITS-1:0]  rem_dec;
   logic                 done;
   logic                 failed;
   logic                 inv_tmp;
   logic [1:0]           cnt;
   result_type           rtmp;

   function automatic result_type make_result(input logic [2:0] kind,
                                              input logic [7:0] rtype,
                                              input logic [7:0] pay,
                                              input logic rend,
                                              input logic [31:0] ival,
                                              input logic ecode,
                                              input logic [OFFSET_BITS-1:0] eoff,
                                              input logic lst);
      result_type r;
      r.kind         = kind;
      r.record_type  = rtype;
      r.payload_byte = pay;
      r.record_end   = rend;
      r.int_value    = ival;
      r.error_code   = ecode;
      r.error_offset = ERR_OFFSET_BITS'(eoff);
      r.last         = lst;
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      inv_in   = inv_ff;
      acc_in   = acc_ff;
      results  = '0;
      failed   = 1'b0;
      cnt      = 2'd0;
      rtmp     = '0;
      inv_tmp  = 1'b0;
      len_full = {len_ff[LEN_BITS-1:8], data_byte};
      rem_dec  = rem_ff - LEN_BITS'(1);
      done     = (rem_dec == '0);

      unique case (phase_ff)
         PH_ERROR: begin
         end
         PH_TYPE: begin
            start_in = pos_ff;
            type_in  = data_byte;
            inv_in   = 1'b0;
            acc_in   = '0;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = {data_byte, 8'h00};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in = len_full;
            rem_in = len_full;
            if (type_ff == TYPE_TEXT) begin
               inv_tmp = (len_full == '0) || (len_full > max_len);
            end else if (type_ff == TYPE_INT) begin
               inv_tmp = (len_full != INT_LEN);
            end
            inv_in = inv_tmp;
            if (len_full == '0) begin
               if (inv_tmp) begin
                  results.res0 = make_result(KIND_ERROR, type_ff, 8'h00, 1'b0, '0,
                                             ERR_INVALID, start_ff, 1'b1);
                  failed = 1'b1;
               end else begin
                  results.res0 = make_result(KIND_EMPTY, type_ff, 8'h00, 1'b1, '0,
                                             ERR_TRUNCATED, '0, 1'b0);
               end
               cnt      = 2'd1;
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            rem_in = rem_dec;
            if (type_ff == TYPE_INT) begin
               acc_in = {acc_ff[23:0], data_byte};
               if (done) begin
                  if (inv_ff) begin
                     results.res0 = make_result(KIND_ERROR, type_ff, 8'h00, 1'b0, '0,
                                                ERR_INVALID, start_ff, 1'b1);
                     failed = 1'b1;
                  end else begin
                     results.res0 = make_result(KIND_INT, type_ff, 8'h00, 1'b1,
                                                {acc_ff[23:0], data_byte},
                                                ERR_TRUNCATED, '0, 1'b0);
                  end
                  cnt = 2'd1;
               end
            end else begin
               inv_tmp = inv_ff || ((type_ff == TYPE_TEXT) &&
                         ((data_byte < TEXT_LOW) || (data_byte > TEXT_HIGH)));
               inv_in  = inv_tmp;
               if (!inv_tmp) begin
                  results.res0 = make_result(KIND_PAYLOAD, type_ff, data_byte, done, '0,
                                             ERR_TRUNCATED, '0, 1'b0);
                  cnt = 2'd1;
               end else if (done) begin
                  results.res0 = make_result(KIND_ERROR, type_ff, 8'h00, 1'b0, '0,
                                             ERR_INVALID, start_ff, 1'b1);
                  cnt    = 2'd1;
                  failed = 1'b1;
               end
            end
            if (done) begin
               phase_in = PH_TYPE;
            end
         end
         default: begin
         end
      endcase

      if (phase_ff != PH_ERROR) begin
         pos_in = (pos_ff >= POS_MAX) ? POS_MAX : pos_ff + OFFSET_BITS'(1);
         if (failed) begin
            if (!buffer_end) begin
               phase_in = PH_ERROR;
            end
         end else if (buffer_end) begin
            if (phase_in != PH_TYPE) begin
               rtmp = make_result(KIND_ERROR, type_in, 8'h00, 1'b0, '0,
                                  ERR_TRUNCATED, start_in, 1'b1);
            end else begin
               rtmp = make_result(KIND_OK, 8'h00, 8'h00, 1'b0, '0,
                                  ERR_TRUNCATED, '0, 1'b1);
            end
            if (cnt == 2'd0) begin
               results.res0 = rtmp;
            end else begin
               results.res1 = rtmp;
            end
            cnt = cnt + 2'd1;
         end
      end

      if (buffer_end) begin
         phase_in = PH_TYPE;
         type_in  = '0;
         len_in   = '0;
         rem_in   = '0;
         start_in = '0;
         pos_in   = '0;
         inv_in   = 1'b0;
         acc_in   = '0;
      end

      results.push0 = accept && (cnt != 2'd0);
      results.push1 = accept && (cnt == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         type_ff  <= '0;
         len_ff   <= '0;
         rem_ff   <= '0;
         start_ff <= '0;
         pos_ff   <= '0;
         inv_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         inv_ff   <= inv_in;
         acc_ff   <= acc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      results.push1 |-> (results.res1.last && !results.res0.last))
      else $error("second result is not a buffer terminator after a record result");

   assert property (@(posedge clock) disable iff (reset)
      (accept && buffer_end) |=> (phase_ff == PH_TYPE && pos_ff == '0))
      else $error("parser not restarted after buffer end");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |-> !results.push0)
      else $error("result produced while discarding an errored buffer");

endmodule

// ===== src/tlvp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// tlvp_out_fifo
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module tlvp_out_fifo
   import tlvp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_pair_type wr,
   output logic            room,
   output logic            out_valid,
   input  logic            out_ready,
   output result_type      out_data
);

   result_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff,  count_in;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(wr.push0) + FIFO_PTR_W'(wr.push1);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(wr.push0) + FIFO_CNT_W'(wr.push1)
                  - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (wr.push0) begin
         mem_ff[wr_ptr_ff] <= wr.res0;
      end
      if (wr.push1) begin
         mem_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= wr.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      wr.push1 |-> wr.push0)
      else $error("second write without first");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers disagree on empty queue");

endmodule

// ===== src/tlv_record_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tlv_record_stream_parser
// Parses type-length-value records from a byte stream, one byte per
// transaction, and emits payload, integer, empty, ok and error results.
//
//   channel  dir  width  contents
//   req      in   8+1    data byte, tlast = buffer end
//   rsp      out  80+3+1 record result, tuser = kind, tlast = last of buffer
//   csr      in   16     max_string_length write
//
// One byte is accepted per cycle while the four-entry result queue has room
// for two entries; its results are written into the queue on acceptance.
// A byte that gives two results (record result plus buffer terminator) sends
// them as two transfers on the single rsp port. Reset is synchronous and
// clears parser and queue. An rsp stall stops req above two queued results.
// ----------------------------------------------------------------------------
module tlv_record_stream_parser
   import tlvp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // record_type, payload_byte, record_end,
                                    // int_value, error_code, error_offset, zero pad
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [LEN_BITS-1:0] max_len_ff;
   logic                accept;
   result_pair_type     pair;
   result_type          head;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign accept = req_tvalid && req_tready;

   tlvp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .buffer_end (req_tlast),
      .max_len    (max_len_ff),
      .results    (pair)
   );

   tlvp_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr        (pair),
      .room      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {6'd0, head.error_offset, head.error_code, head.int_value,
                       head.record_end, head.payload_byte, head.record_type};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
